[design/srp_pkg.sv]
// Shared constants, phase codes and payload types of the subtitle record parser.
package srp_pkg;

    localparam int unsigned MAX_BLOCK_BYTES = 65535;

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_LEN0  = 5'd1;
    localparam logic [4:0] PH_LEN1  = 5'd2;
    localparam logic [4:0] PH_LANG  = 5'd3;
    localparam logic [4:0] PH_TEXT  = 5'd4;
    localparam logic [4:0] PH_OFF0  = 5'd5;
    localparam logic [4:0] PH_OFF1  = 5'd6;
    localparam logic [4:0] PH_DUR0  = 5'd7;
    localparam logic [4:0] PH_DUR1  = 5'd8;
    localparam logic [4:0] PH_DUR2  = 5'd9;
    localparam logic [4:0] PH_DUR3  = 5'd10;
    localparam logic [4:0] PH_XPOS  = 5'd11;
    localparam logic [4:0] PH_YPOS  = 5'd12;
    localparam logic [4:0] PH_RED   = 5'd13;
    localparam logic [4:0] PH_GRN   = 5'd14;
    localparam logic [4:0] PH_BLU   = 5'd15;
    localparam logic [4:0] PH_FONT  = 5'd16;
    localparam logic [4:0] PH_EXTRA = 5'd17;
    localparam logic [4:0] PH_SKIP  = 5'd18;

    localparam logic [2:0] KIND_LANG   = 3'd0;
    localparam logic [2:0] KIND_TEXT   = 3'd1;
    localparam logic [2:0] KIND_EXTRA  = 3'd2;
    localparam logic [2:0] KIND_HEADER = 3'd3;
    localparam logic [2:0] KIND_DROP   = 3'd4;

    // Minimum record bytes left when a language or text terminator arrives.
    localparam logic [15:0] LANG_TERM_MIN = 16'd2;
    localparam logic [15:0] TEXT_TERM_MIN = 16'd7;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        first_byte;
        logic [15:0] block_length;
        logic [31:0] base_frame;
    } srp_item_t;

    typedef struct packed {
        logic [7:0]        x_position;
        logic [7:0]        y_position;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [7:0] font_size;
    } srp_attr_t;

    localparam srp_attr_t ATTR_DEFAULTS = '{
        x_position: 8'd128,
        y_position: 8'd255,
        red:        8'd255,
        green:      8'd255,
        blue:       8'd255,
        font_size:  8'sd0
    };

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        data_byte;
        logic              record_done;
        logic [31:0]       show_frame;
        logic [31:0]       hide_frame;
        logic [7:0]        x_position;
        logic [7:0]        y_position;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
        logic signed [7:0] font_size;
    } srp_result_t;

endpackage

[design/srp_byte_if.sv]
// Handshake channel that carries one byte of a subtitle block per word.
interface srp_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic        first_byte;
    logic [15:0] block_length;
    logic [31:0] base_frame;

    modport source (
        output valid,
        output byte_value,
        output first_byte,
        output block_length,
        output base_frame,
        input  ready
    );

    modport sink (
        input  valid,
        input  byte_value,
        input  first_byte,
        input  block_length,
        input  base_frame,
        output ready
    );
endinterface

[design/srp_result_if.sv]
// Handshake channel that carries one parser result per word.
interface srp_result_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [7:0]        data_byte;
    logic              record_done;
    logic [31:0]       show_frame;
    logic [31:0]       hide_frame;
    logic [7:0]        x_position;
    logic [7:0]        y_position;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic signed [7:0] font_size;

    modport source (
        output valid,
        output kind,
        output data_byte,
        output record_done,
        output show_frame,
        output hide_frame,
        output x_position,
        output y_position,
        output red,
        output green,
        output blue,
        output font_size,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  data_byte,
        input  record_done,
        input  show_frame,
        input  hide_frame,
        input  x_position,
        input  y_position,
        input  red,
        input  green,
        input  blue,
        input  font_size,
        output ready
    );
endinterface

[design/srp_parse_core.sv]
// Record parsing state and the per-byte next-state and result logic.
module srp_parse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  srp_pkg::srp_item_t  item,
    output logic                res_valid,
    output srp_pkg::srp_result_t res
);
    import srp_pkg::*;

    logic [4:0]  phase_reg, phase_next;
    logic [15:0] block_left_reg, block_left_next;
    logic [15:0] record_left_reg, record_left_next;
    logic [31:0] frame_base_reg, frame_base_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    srp_attr_t   attr_reg, attr_next;

    logic        abandoned;
    logic [4:0]  ph;
    logic [4:0]  tail_next;
    logic [15:0] bl;
    logic [15:0] rl;
    logic [15:0] rdec;
    logic [15:0] rlen;
    logic [7:0]  b;
    logic        emit;
    logic [2:0]  emit_kind;
    logic [7:0]  emit_data;
    logic        emit_done;

    always_comb
    begin
        phase_next       = phase_reg;
        block_left_next  = block_left_reg;
        record_left_next = record_left_reg;
        frame_base_next  = frame_base_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        attr_next        = attr_reg;
        abandoned        = 1'b0;
        ph               = phase_reg;
        bl               = block_left_reg;
        rl               = record_left_reg;
        b                = item.byte_value;
        rdec             = (rl != 16'd0) ? rl - 16'd1 : 16'd0;
        rlen             = {b, rl[7:0]};
        tail_next        = phase_reg + 5'd1;
        emit             = 1'b0;
        emit_kind        = KIND_DROP;
        emit_data        = 8'd0;
        emit_done        = 1'b0;

        // A first byte restarts the block whatever the parser was doing.
        if (item.first_byte)
        begin
            abandoned       = (phase_reg >= PH_LANG);
            bl              = (17'(item.block_length) > 17'(MAX_BLOCK_BYTES))
                              ? 16'(MAX_BLOCK_BYTES) : item.block_length;
            frame_base_next = item.base_frame;
            ph              = PH_LEN0;
            phase_next      = PH_LEN0;
        end

        if (ph != PH_IDLE)
        begin
            block_left_next = (bl != 16'd0) ? bl - 16'd1 : 16'd0;
            case (ph)
                PH_LEN0:
                begin
                    if (bl <= 16'd2)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        record_left_next = {8'd0, b};
                        phase_next       = PH_LEN1;
                    end
                    emit = abandoned;
                end
                PH_LEN1:
                begin
                    // bl is at least two here, so rlen >= bl is rlen > bl - 1.
                    if (rlen == 16'd0 || rlen >= bl)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        record_left_next = rlen;
                        attr_next        = ATTR_DEFAULTS;
                        phase_next       = PH_LANG;
                    end
                end
                PH_LANG, PH_TEXT:
                begin
                    if (b != 8'd0)
                    begin
                        emit = 1'b1;
                        if (rl <= 16'd1)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            record_left_next = rl - 16'd1;
                            emit_kind        = (ph == PH_LANG) ? KIND_LANG : KIND_TEXT;
                            emit_data        = b;
                        end
                    end
                    else if (rl < ((ph == PH_LANG) ? LANG_TERM_MIN : TEXT_TERM_MIN))
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                    end
                    else
                    begin
                        record_left_next = rl - 16'd1;
                        phase_next       = (ph == PH_LANG) ? PH_TEXT : PH_OFF0;
                    end
                end
                default:
                begin
                    record_left_next = rdec;
                    case (ph)
                        PH_OFF0: start_next = {24'd0, b};
                        PH_OFF1: start_next = frame_base_reg + {16'd0, b, start_reg[7:0]};
                        PH_DUR0: end_next = {24'd0, b};
                        PH_DUR1: end_next[15:8] = b;
                        PH_DUR2: end_next[23:16] = b;
                        PH_DUR3:
                        begin
                            end_next  = start_reg + {b, end_reg[23:0]};
                            tail_next = (rdec >= 16'd2) ? PH_XPOS : PH_SKIP;
                        end
                        PH_XPOS: attr_next.x_position = b;
                        PH_YPOS:
                        begin
                            attr_next.y_position = b;
                            tail_next = (rdec >= 16'd3) ? PH_RED : PH_SKIP;
                        end
                        PH_RED:   attr_next.red = b;
                        PH_GRN:   attr_next.green = b;
                        PH_BLU:   attr_next.blue = b;
                        PH_FONT:  attr_next.font_size = b;
                        PH_EXTRA: tail_next = PH_EXTRA;
                        PH_SKIP:  tail_next = PH_SKIP;
                        default:  tail_next = PH_IDLE;
                    endcase

                    if (tail_next == PH_IDLE)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (ph == PH_EXTRA)
                    begin
                        // Extra bytes always go out; the last one also closes the record.
                        emit       = 1'b1;
                        emit_kind  = KIND_EXTRA;
                        emit_data  = b;
                        emit_done  = (rdec == 16'd0);
                        phase_next = (rdec == 16'd0) ? PH_LEN0 : PH_EXTRA;
                    end
                    else if (rdec == 16'd0)
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_HEADER;
                        emit_done  = 1'b1;
                        phase_next = PH_LEN0;
                    end
                    else
                    begin
                        phase_next = tail_next;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid       = emit;
        res             = '0;
        res.kind        = emit_kind;
        res.data_byte   = emit_data;
        res.record_done = emit_done;
        if (emit_done)
        begin
            res.show_frame  = start_next;
            res.hide_frame  = end_next;
            res.x_position  = attr_next.x_position;
            res.y_position  = attr_next.y_position;
            res.red         = attr_next.red;
            res.green       = attr_next.green;
            res.blue        = attr_next.blue;
            res.font_size   = attr_next.font_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            block_left_reg  <= 16'd0;
            record_left_reg <= 16'd0;
            frame_base_reg  <= 32'd0;
            start_reg       <= 32'd0;
            end_reg         <= 32'd0;
            attr_reg        <= ATTR_DEFAULTS;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            block_left_reg  <= block_left_next;
            record_left_reg <= record_left_next;
            frame_base_reg  <= frame_base_next;
            start_reg       <= start_next;
            end_reg         <= end_next;
            attr_reg        <= attr_next;
        end
    end

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_IDLE && !item.first_byte) |-> !res_valid)
        else $error("result produced while the block is stopped");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.record_done) |-> (res.kind == KIND_HEADER || res.kind == KIND_EXTRA))
        else $error("record closed by a result of the wrong kind");

    a_drop_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid && res.kind == KIND_DROP && !item.first_byte)
        |=> phase_reg == PH_IDLE)
        else $error("parser kept running after a dropped record");

endmodule

[design/srp_out_buffer.sv]
// Two-entry output register with skid stage between the parser and the result channel.
module srp_out_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srp_pkg::srp_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srp_pkg::srp_result_t out_data
);
    import srp_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    srp_result_t main_reg, main_next;
    srp_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            // The skid word, when present, is older than anything arriving now.
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("word pushed while the skid stage is full");

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds a word while the output register is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid word not moved forward after the output was taken");

endmodule

[design/subtitle_record_parser.sv]
// Top level of the subtitle record parser: byte channel in, result channel out.
//
//   Channel   Modport   Word                         Accepted when
//   stream    sink      one block byte + block info  stream.valid && stream.ready
//   result    source    one parser result            result.valid && result.ready
//
// One byte is taken every cycle while stream.ready is high; the result it causes is
// registered in the output stage. The parse state sits in a single register set that
// is updated by one pass of next-state logic per byte. stream.ready drops only while
// the two-entry output stage is full, that is after two results are held by a stall.
// Reset is asynchronous and active low; it stops the block until a first byte arrives.
module subtitle_record_parser (
    input  logic         clk,
    input  logic         rst_n,
    srp_byte_if.sink     stream,
    srp_result_if.source result
);
    import srp_pkg::*;

    srp_item_t   item;
    srp_result_t core_res;
    srp_result_t out_res;
    logic        core_res_valid;
    logic        can_push;
    logic        accept;

    assign item.byte_value   = stream.byte_value;
    assign item.first_byte   = stream.first_byte;
    assign item.block_length = stream.block_length;
    assign item.base_frame   = stream.base_frame;

    assign stream.ready = can_push;
    assign accept       = stream.valid && can_push;

    srp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    srp_out_buffer u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && core_res_valid),
        .push_data (core_res),
        .can_push  (can_push),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_res)
    );

    assign result.kind        = out_res.kind;
    assign result.data_byte   = out_res.data_byte;
    assign result.record_done = out_res.record_done;
    assign result.show_frame  = out_res.show_frame;
    assign result.hide_frame  = out_res.hide_frame;
    assign result.x_position  = out_res.x_position;
    assign result.y_position  = out_res.y_position;
    assign result.red         = out_res.red;
    assign result.green       = out_res.green;
    assign result.blue        = out_res.blue;
    assign result.font_size   = out_res.font_size;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the subtitle record parser: directed and random blocks.
module tb_top;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;

    srp_byte_if   stream ();
    srp_result_if result ();

    subtitle_record_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .result (result)
    );

    always #2 clk = ~clk;

    // Mirror of the parse state, advanced once per accepted word.
    logic [4:0]  parse_phase;
    int unsigned block_left;
    int unsigned record_left;
    logic [31:0] frame_origin;
    logic [31:0] start_acc;
    logic [31:0] end_acc;
    srp_attr_t   attr_now;

    srp_result_t expected_results[$];
    bit          steady = 1'b0;
    int          errors = 0;
    int          cycles = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          complete_records = 0;
    int          dropped_records = 0;

    function automatic srp_result_t make_result(logic [2:0] k, logic [7:0] d, bit done);
        srp_result_t r;
        r = '0;
        r.kind = k;
        r.data_byte = d;
        r.record_done = done;
        if (done)
        begin
            r.show_frame = start_acc;
            r.hide_frame = end_acc;
            r.x_position = attr_now.x_position;
            r.y_position = attr_now.y_position;
            r.red = attr_now.red;
            r.green = attr_now.green;
            r.blue = attr_now.blue;
            r.font_size = attr_now.font_size;
        end
        return r;
    endfunction

    function automatic void parse_byte(input srp_item_t w, output bit emitted,
                                       output srp_result_t res);
        bit          abandoned;
        int unsigned bl;
        int unsigned rl;
        int unsigned r;
        logic [4:0]  nxt;
        logic [31:0] b;
        emitted = 1'b0;
        res = '0;
        abandoned = 1'b0;
        b = 32'(w.byte_value);
        if (w.first_byte)
        begin
            abandoned = parse_phase >= PH_LANG;
            block_left = (w.block_length > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES
                                                            : w.block_length;
            frame_origin = w.base_frame;
            parse_phase = PH_LEN0;
        end
        if (parse_phase == PH_IDLE)
            return;
        bl = block_left;
        block_left = (bl != 0) ? bl - 1 : 0;
        rl = record_left;

        case (parse_phase)
            PH_LEN0:
            begin
                if (bl <= 2)
                    parse_phase = PH_IDLE;
                else
                begin
                    record_left = b;
                    parse_phase = PH_LEN1;
                end
                if (abandoned)
                begin
                    emitted = 1'b1;
                    res = make_result(KIND_DROP, 8'd0, 1'b0);
                end
                return;
            end
            PH_LEN1:
            begin
                r = rl | (b << 8);
                if (r == 0 || r > bl - 1)
                begin
                    parse_phase = PH_IDLE;
                    emitted = 1'b1;
                    res = make_result(KIND_DROP, 8'd0, 1'b0);
                    return;
                end
                record_left = r;
                attr_now = ATTR_DEFAULTS;
                parse_phase = PH_LANG;
                return;
            end
            PH_LANG, PH_TEXT:
            begin
                emitted = 1'b1;
                if (b != 0)
                begin
                    if (rl <= 1)
                    begin
                        parse_phase = PH_IDLE;
                        res = make_result(KIND_DROP, 8'd0, 1'b0);
                        return;
                    end
                    record_left = rl - 1;
                    res = make_result((parse_phase == PH_LANG) ? KIND_LANG : KIND_TEXT,
                                      b[7:0], 1'b0);
                    return;
                end
                if (rl < ((parse_phase == PH_LANG) ? LANG_TERM_MIN : TEXT_TERM_MIN))
                begin
                    parse_phase = PH_IDLE;
                    res = make_result(KIND_DROP, 8'd0, 1'b0);
                    return;
                end
                emitted = 1'b0;
                record_left = rl - 1;
                parse_phase = (parse_phase == PH_LANG) ? PH_TEXT : PH_OFF0;
                return;
            end
            default: ;
        endcase

        r = (rl != 0) ? rl - 1 : 0;
        record_left = r;
        nxt = parse_phase + 5'd1;
        case (parse_phase)
            PH_OFF0: start_acc = b;
            PH_OFF1: start_acc = frame_origin + (start_acc | (b << 8));
            PH_DUR0: end_acc = b;
            PH_DUR1: end_acc = end_acc | (b << 8);
            PH_DUR2: end_acc = end_acc | (b << 16);
            PH_DUR3:
            begin
                end_acc = start_acc + (end_acc | (b << 24));
                nxt = (r >= 2) ? PH_XPOS : PH_SKIP;
            end
            PH_XPOS: attr_now.x_position = b[7:0];
            PH_YPOS:
            begin
                attr_now.y_position = b[7:0];
                nxt = (r >= 3) ? PH_RED : PH_SKIP;
            end
            PH_RED:  attr_now.red = b[7:0];
            PH_GRN:  attr_now.green = b[7:0];
            PH_BLU:  attr_now.blue = b[7:0];
            PH_FONT: attr_now.font_size = b[7:0];
            PH_EXTRA:
            begin
                emitted = 1'b1;
                if (r == 0)
                begin
                    parse_phase = PH_LEN0;
                    res = make_result(KIND_EXTRA, b[7:0], 1'b1);
                end
                else
                    res = make_result(KIND_EXTRA, b[7:0], 1'b0);
                return;
            end
            PH_SKIP: nxt = PH_SKIP;
            default:
            begin
                parse_phase = PH_IDLE;
                return;
            end
        endcase

        if (r == 0)
        begin
            parse_phase = PH_LEN0;
            emitted = 1'b1;
            res = make_result(KIND_HEADER, 8'd0, 1'b1);
            return;
        end
        parse_phase = nxt;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Results are checked and accepted words predicted from the values sampled at the edge.
    always @(posedge clk)
    begin
        srp_item_t   w;
        srp_result_t got;
        srp_result_t want;
        bit          emitted;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                results_seen++;
                got.kind = result.kind;
                got.data_byte = result.data_byte;
                got.record_done = result.record_done;
                got.show_frame = result.show_frame;
                got.hide_frame = result.hide_frame;
                got.x_position = result.x_position;
                got.y_position = result.y_position;
                got.red = result.red;
                got.green = result.green;
                got.blue = result.blue;
                got.font_size = result.font_size;
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d", got.kind);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("kind", 32'(want.kind), 32'(got.kind));
                    report_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
                    report_field("record_done", 32'(want.record_done), 32'(got.record_done));
                    report_field("show_frame", want.show_frame, got.show_frame);
                    report_field("hide_frame", want.hide_frame, got.hide_frame);
                    report_field("x_position", 32'(want.x_position), 32'(got.x_position));
                    report_field("y_position", 32'(want.y_position), 32'(got.y_position));
                    report_field("red", 32'(want.red), 32'(got.red));
                    report_field("green", 32'(want.green), 32'(got.green));
                    report_field("blue", 32'(want.blue), 32'(got.blue));
                    report_field("font_size", 32'(want.font_size), 32'(got.font_size));
                end
            end
            if (stream.valid && stream.ready)
            begin
                w.byte_value = stream.byte_value;
                w.first_byte = stream.first_byte;
                w.block_length = stream.block_length;
                w.base_frame = stream.base_frame;
                parse_byte(w, emitted, want);
                if (emitted)
                begin
                    expected_results.push_back(want);
                    if (want.record_done)
                        complete_records++;
                    if (want.kind == KIND_DROP)
                        dropped_records++;
                end
            end
        end
    end

    always @(posedge clk)
        result.ready <= steady || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_word(input srp_item_t w);
        while (!steady && $urandom_range(99) < 16)
        begin
            stream.valid <= 1'b0;
            @(posedge clk);
        end
        stream.valid <= 1'b1;
        stream.byte_value <= w.byte_value;
        stream.first_byte <= w.first_byte;
        stream.block_length <= w.block_length;
        stream.base_frame <= w.base_frame;
        @(posedge clk);
        while (!stream.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Block information is only sampled on the first word, so it is random elsewhere.
    task automatic send_block(input byte_q_t q, input logic [15:0] blen,
                              input logic [31:0] base);
        srp_item_t w;
        for (int i = 0; i < q.size(); i++)
        begin
            w.byte_value = q[i];
            w.first_byte = (i == 0);
            w.block_length = (i == 0) ? blen : 16'($urandom);
            w.base_frame = (i == 0) ? base : $urandom;
            send_word(w);
        end
    endtask

    task automatic send_loose(input int n);
        srp_item_t w;
        for (int i = 0; i < n; i++)
        begin
            w.byte_value = 8'($urandom);
            w.first_byte = 1'b0;
            w.block_length = 16'($urandom);
            w.base_frame = $urandom;
            send_word(w);
        end
    endtask

    function automatic void add_record(ref byte_q_t q, input int lang_n, input int text_n,
                                       input logic [15:0] offset, input logic [31:0] dur,
                                       input int tail_n);
        logic [15:0] len;
        len = 16'(lang_n + text_n + 8 + tail_n);
        q.push_back(len[7:0]);
        q.push_back(len[15:8]);
        for (int i = 0; i < lang_n; i++)
            q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'h00);
        for (int i = 0; i < text_n; i++)
            q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'h00);
        q.push_back(offset[7:0]);
        q.push_back(offset[15:8]);
        for (int i = 0; i < 4; i++)
            q.push_back(dur[8*i +: 8]);
        for (int i = 0; i < tail_n; i++)
            q.push_back(8'($urandom));
    endfunction

    // One record for each tail length, so every attribute and the skip paths are hit.
    task automatic test_well_formed_records();
        byte_q_t q;
        q = {};
        for (int t = 0; t <= 8; t++)
            add_record(q, t % 3, (t + 1) % 4, (t % 2) ? 16'hFFFF : 16'h0000,
                       (t % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, t);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        send_block(q, 16'(q.size()), 32'hFFFF_FFF0);
    endtask

    task automatic test_malformed_records();
        byte_q_t q;
        // Zero record length.
        send_block('{8'h00, 8'h00, 8'h41, 8'h00}, 16'd4, 32'd0);
        // Record length beyond the end of the block.
        send_block('{8'h14, 8'h00, 8'h41, 8'h42}, 16'd4, 32'd7);
        // Language string that runs into the end of the record.
        send_block('{8'h02, 8'h00, 8'h61, 8'h62, 8'h00}, 16'd5, 32'd1);
        // Language terminator on the last byte of the record.
        send_block('{8'h01, 8'h00, 8'h00}, 16'd3, 32'd2);
        // Text terminator without room for the offset and duration.
        send_block('{8'h06, 8'h00, 8'h00, 8'h74, 8'h00, 8'h01, 8'h02, 8'h03}, 16'd8, 32'd3);
        // Text string that runs into the end of the record.
        send_block('{8'h03, 8'h00, 8'h00, 8'h78, 8'h79}, 16'd5, 32'd4);
        // Bytes after a stopped block are ignored.
        send_loose(3);
        // Too few bytes for a record, and an empty block.
        send_block('{8'h05, 8'h00}, 16'd2, 32'd5);
        send_block('{8'h05, 8'h00, 8'h01}, 16'd0, 32'd6);
        // A record abandoned by a new block.
        q = {};
        add_record(q, 2, 3, 16'h1234, 32'h0000_0100, 4);
        q = q[0:6];
        send_block(q, 16'd40, 32'h8000_0000);
        q = {};
        add_record(q, 1, 1, 16'h00FF, 32'h7FFF_FFFF, 6);
        send_block(q, 16'hFFFF, 32'h7FFF_FFFF);
        send_block('{8'h00, 8'h00}, 16'd2, 32'd0);
    endtask

    task automatic test_long_record();
        byte_q_t q;
        q = {};
        add_record(q, 3, 6, 16'h8001, 32'h8000_0001, 300);
        send_block(q, 16'(q.size()), 32'h0123_4567);
    endtask

    // Mostly well-formed blocks of random content, some of them damaged on purpose.
    task automatic test_random_blocks(input int budget);
        byte_q_t     q;
        int          stop_at;
        int          mode;
        int          tail;
        logic [15:0] blen;
        logic [15:0] offset;
        logic [31:0] dur;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at)
        begin
            q = {};
            repeat ($urandom_range(1, 4))
            begin
                offset = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
                dur = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
                tail = ($urandom_range(3) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 8);
                add_record(q, $urandom_range(0, 3), $urandom_range(0, 6), offset, dur, tail);
            end
            repeat ($urandom_range(0, 2))
                q.push_back(8'($urandom));
            blen = 16'(q.size());
            mode = $urandom_range(99);
            if (mode < 6)
                q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            else if (mode < 11)
                q = q[0:$urandom_range(0, q.size() - 1)];
            else if (mode < 15)
                blen = 16'($urandom_range(0, blen + 20));
            send_block(q, blen, $urandom);
            if (mode >= 15 && mode < 18)
                send_loose($urandom_range(1, 4));
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_blocks(150);
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        stream.valid = 1'b0;
        stream.byte_value = 8'd0;
        stream.first_byte = 1'b0;
        stream.block_length = 16'd0;
        stream.base_frame = 32'd0;
        result.ready = 1'b0;
        parse_phase = PH_IDLE;
        block_left = 0;
        record_left = 0;
        frame_origin = '0;
        start_acc = '0;
        end_acc = '0;
        attr_now = ATTR_DEFAULTS;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed_records();
        test_malformed_records();
        test_long_record();
        test_random_blocks(340);
        test_steady_stream();

        stream.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes and checked %0d result words in %0d cycles.",
                 bytes_sent, results_seen, cycles);
        $display("Saw %0d complete records and %0d dropped ones.",
                 complete_records, dropped_records);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

[filelist.f]
design/srp_pkg.sv
design/srp_byte_if.sv
design/srp_result_if.sv
design/srp_parse_core.sv
design/srp_out_buffer.sv
design/subtitle_record_parser.sv
sim/tb_top.sv
